// File: rtl/core/whlc_pkg.sv
// Package for the WLAN MAC header layout classifier.
// Holds the field widths, status, layout and subtype codes, header field flag bits, header lengths and BAR/BA bits.
// No dependencies.
package whlc_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned HLEN_W   = 6;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned SUB_W    = 4;
  localparam int unsigned FCBITS_W = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_TYPE     = 3'd3,
    ST_SUBTYPE  = 3'd4,
    ST_RESERVED = 3'd5,
    ST_EXT      = 3'd6
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MGMT    = 3'd0,
    KIND_WRAPPER = 3'd1,
    KIND_BAR     = 3'd2,
    KIND_CBA     = 3'd3,
    KIND_CTRL2A  = 3'd4,
    KIND_CTRL1A  = 3'd5,
    KIND_DATA    = 3'd6
  } kind_t;

  typedef enum logic [TYPE_W-1:0] {
    FT_MGMT = 2'd0,
    FT_CTRL = 2'd1,
    FT_DATA = 2'd2,
    FT_EXT  = 2'd3
  } ftype_t;

  // Management subtypes
  localparam logic [SUB_W-1:0] MSUB_ASSOC_REQ   = 4'd0;
  localparam logic [SUB_W-1:0] MSUB_RES_6       = 4'd6;
  localparam logic [SUB_W-1:0] MSUB_RES_7       = 4'd7;
  localparam logic [SUB_W-1:0] MSUB_RES_15      = 4'd15;

  // Control subtypes
  localparam logic [SUB_W-1:0] CSUB_RESERVED0   = 4'd0;
  localparam logic [SUB_W-1:0] CSUB_TRIGGER     = 4'd2;
  localparam logic [SUB_W-1:0] CSUB_CTRL_EXT    = 4'd6;
  localparam logic [SUB_W-1:0] CSUB_WRAPPER     = 4'd7;
  localparam logic [SUB_W-1:0] CSUB_BAR         = 4'd8;
  localparam logic [SUB_W-1:0] CSUB_BA          = 4'd9;
  localparam logic [SUB_W-1:0] CSUB_PS_POLL     = 4'd10;
  localparam logic [SUB_W-1:0] CSUB_RTS         = 4'd11;
  localparam logic [SUB_W-1:0] CSUB_CTS         = 4'd12;
  localparam logic [SUB_W-1:0] CSUB_ACK         = 4'd13;
  localparam logic [SUB_W-1:0] CSUB_CF_END      = 4'd14;
  localparam logic [SUB_W-1:0] CSUB_CF_END_ACK  = 4'd15;

  // Data subtypes; the top subtype bit marks QoS data
  localparam logic [SUB_W-1:0] DSUB_DATA        = 4'd0;
  localparam logic [SUB_W-1:0] DSUB_QOS_DATA    = 4'd8;
  localparam int unsigned      DSUB_QOS_BIT     = 3;

  // Header field flag bits
  localparam logic [FLAGS_W-1:0] FL_A1     = 8'h01;
  localparam logic [FLAGS_W-1:0] FL_A2     = 8'h02;
  localparam logic [FLAGS_W-1:0] FL_A3     = 8'h04;
  localparam logic [FLAGS_W-1:0] FL_A4     = 8'h08;
  localparam logic [FLAGS_W-1:0] FL_QOS    = 8'h10;
  localparam logic [FLAGS_W-1:0] FL_HT     = 8'h20;
  localparam logic [FLAGS_W-1:0] FL_BARC   = 8'h40;
  localparam logic [FLAGS_W-1:0] FL_BITMAP = 8'h80;

  // Header lengths in bytes
  localparam logic [HLEN_W-1:0] HLEN_MGMT    = 6'd24;
  localparam logic [HLEN_W-1:0] HLEN_HT      = 6'd4;
  localparam logic [HLEN_W-1:0] HLEN_A4      = 6'd6;
  localparam logic [HLEN_W-1:0] HLEN_QOS     = 6'd2;
  localparam logic [HLEN_W-1:0] HLEN_WRAPPER = 6'd16;
  localparam logic [HLEN_W-1:0] HLEN_BAR     = 6'd20;
  localparam logic [HLEN_W-1:0] HLEN_CBA     = 6'd28;
  localparam logic [HLEN_W-1:0] HLEN_CTRL2A  = 6'd16;
  localparam logic [HLEN_W-1:0] HLEN_CTRL1A  = 6'd10;

  // Minimum lengths that gate decoding
  localparam logic [WORD_W-1:0] LEN_FC_MIN  = 16'd2;
  localparam logic [WORD_W-1:0] LEN_ACK_MIN = 16'd18;

  // BAR/BA control bits
  localparam int unsigned ACK_MULTI_TID_BIT  = 1;
  localparam int unsigned ACK_COMPRESSED_BIT = 2;

endpackage : whlc_pkg

// File: rtl/core/whlc_ifs.sv
// Valid/ready channel interfaces of the header layout classifier.
// Depends on whlc_pkg for field widths.
interface whlc_in_if
  import whlc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] fctl_word;
  logic [WORD_W-1:0] ack_control;
  logic [WORD_W-1:0] frame_length;

  modport source (output valid, fctl_word, ack_control, frame_length, input ready);
  modport sink   (input valid, fctl_word, ack_control, frame_length, output ready);
endinterface : whlc_in_if

interface whlc_out_if
  import whlc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                control_word_valid;
  logic                header_length_valid;
  logic [KIND_W-1:0]   hdr_layout;
  logic [FLAGS_W-1:0]  field_flags;
  logic [HLEN_W-1:0]   min_header_bytes;
  logic [TYPE_W-1:0]   fctl_type;
  logic [SUB_W-1:0]    frame_subtype;
  logic [FCBITS_W-1:0] frame_flag_bits;

  modport source (output valid, status, control_word_valid, header_length_valid, hdr_layout,
                  field_flags, min_header_bytes, fctl_type, frame_subtype, frame_flag_bits,
                  input ready);
  modport sink   (input valid, status, control_word_valid, header_length_valid, hdr_layout,
                  field_flags, min_header_bytes, fctl_type, frame_subtype, frame_flag_bits,
                  output ready);
endinterface : whlc_out_if

// File: rtl/core/wlan_mac_header_layout_classifier.sv
// Each accepted input beat is held in the input register, then in the result
// register, which drives out_bus. One beat per cycle while the sink takes results;
// both stages advance together when the result register is empty or being drained.
// Reset: rst_n (synchronous, active low) clears both stage valid flags; payload
// registers are not reset.
// Depends on whlc_pkg and the channel interfaces in whlc_ifs.sv.
module wlan_mac_header_layout_classifier
  import whlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  whlc_in_if.sink     in_bus,
  whlc_out_if.source  out_bus
);

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic              in_vld_r;
  logic [WORD_W-1:0] fc_r;
  logic [WORD_W-1:0] ack_r;
  logic [WORD_W-1:0] len_r;

  // Result register is free when empty or taken this cycle
  logic out_free;
  logic in_free;

  assign out_free     = !out_bus.valid || out_bus.ready;
  assign in_free      = !in_vld_r || out_free;
  assign in_bus.ready = in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_free) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_bus.valid) begin
      fc_r  <= in_bus.fctl_word;
      ack_r <= in_bus.ack_control;
      len_r <= in_bus.frame_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Classification: decode the control word, pick the layout, check length
  // ---------------------------------------------------------------------------
  status_t             status_nxt;
  logic                cwv_nxt;
  logic                hvalid_nxt;
  logic [KIND_W-1:0]   kind_nxt;
  logic [FLAGS_W-1:0]  flags_nxt;
  logic [HLEN_W-1:0]   hlen_nxt;
  logic [TYPE_W-1:0]   type_nxt;
  logic [SUB_W-1:0]    sub_nxt;
  logic [FCBITS_W-1:0] fcbits_nxt;

  always_comb begin
    status_t            cls_st;
    kind_t              lay_kind;
    logic [FLAGS_W-1:0] lay_flags;
    logic [HLEN_W-1:0]  lay_hlen;
    ftype_t             ftype;
    logic [SUB_W-1:0]   sub;
    logic               to_ds;
    logic               from_ds;
    logic               order;

    ftype   = ftype_t'(fc_r[3:2]);
    sub     = fc_r[7:4];
    to_ds   = fc_r[8];
    from_ds = fc_r[9];
    order   = fc_r[15];

    cls_st    = ST_OK;
    lay_kind  = KIND_MGMT;
    lay_flags = '0;
    lay_hlen  = '0;

    if (fc_r[1:0] != 2'b00) begin
      cls_st = ST_VERSION;
    end else begin
      unique case (ftype)
        FT_MGMT: begin
          if (sub == MSUB_RES_6 || sub == MSUB_RES_7 || sub == MSUB_RES_15) begin
            cls_st = ST_RESERVED;
          end else begin
            lay_kind  = KIND_MGMT;
            lay_flags = FL_A1 | FL_A2 | FL_A3 | (order ? FL_HT : '0);
            lay_hlen  = HLEN_MGMT + (order ? HLEN_HT : '0);
          end
        end
        FT_CTRL: begin
          unique case (sub)
            CSUB_WRAPPER: begin
              lay_kind  = KIND_WRAPPER;
              lay_flags = FL_A1 | FL_HT;
              lay_hlen  = HLEN_WRAPPER;
            end
            CSUB_BAR, CSUB_BA: begin
              // BAR/BA control word must be in the capture before it is trusted
              priority if (len_r < LEN_ACK_MIN) begin
                cls_st = ST_TRUNC;
              end else if (ack_r[ACK_MULTI_TID_BIT]) begin
                cls_st = ST_EXT;
              end else if (sub == CSUB_BAR) begin
                lay_kind  = KIND_BAR;
                lay_flags = FL_A1 | FL_A2 | FL_BARC;
                lay_hlen  = HLEN_BAR;
              end else if (!ack_r[ACK_COMPRESSED_BIT]) begin
                cls_st = ST_EXT; // basic BA
              end else begin
                lay_kind  = KIND_CBA;
                lay_flags = FL_A1 | FL_A2 | FL_BARC | FL_BITMAP;
                lay_hlen  = HLEN_CBA;
              end
            end
            CSUB_PS_POLL, CSUB_RTS, CSUB_CF_END, CSUB_CF_END_ACK: begin
              lay_kind  = KIND_CTRL2A;
              lay_flags = FL_A1 | FL_A2;
              lay_hlen  = HLEN_CTRL2A;
            end
            CSUB_CTS, CSUB_ACK: begin
              lay_kind  = KIND_CTRL1A;
              lay_flags = FL_A1;
              lay_hlen  = HLEN_CTRL1A;
            end
            CSUB_TRIGGER, CSUB_CTRL_EXT: cls_st = ST_SUBTYPE;
            default:                     cls_st = ST_RESERVED;
          endcase
        end
        FT_DATA: begin
          lay_kind  = KIND_DATA;
          lay_flags = FL_A1 | FL_A2 | FL_A3;
          lay_hlen  = HLEN_MGMT;
          if (to_ds && from_ds) begin
            lay_flags = lay_flags | FL_A4;
            lay_hlen  = lay_hlen + HLEN_A4;
          end
          if (sub[DSUB_QOS_BIT]) begin
            lay_flags = lay_flags | FL_QOS;
            lay_hlen  = lay_hlen + HLEN_QOS;
            if (order) begin
              lay_flags = lay_flags | FL_HT;
              lay_hlen  = lay_hlen + HLEN_HT;
            end
          end
        end
        default: cls_st = ST_TYPE; // extension frames
      endcase
    end

    status_nxt = ST_OK;
    cwv_nxt    = 1'b0;
    hvalid_nxt = 1'b0;
    kind_nxt   = '0;
    flags_nxt  = '0;
    hlen_nxt   = '0;
    type_nxt   = '0;
    sub_nxt    = '0;
    fcbits_nxt = '0;

    if (len_r < LEN_FC_MIN) begin
      // Frame control not captured: everything else reads zero
      status_nxt = ST_TRUNC;
    end else begin
      cwv_nxt    = 1'b1;
      type_nxt   = fc_r[3:2];
      sub_nxt    = sub;
      fcbits_nxt = {fc_r[15:14], fc_r[11:8]};
      status_nxt = cls_st;
      if (cls_st == ST_OK) begin
        hvalid_nxt = 1'b1;
        if (len_r < {{(WORD_W-HLEN_W){1'b0}}, lay_hlen}) begin
          status_nxt = ST_TRUNC;
        end else begin
          kind_nxt  = lay_kind;
          flags_nxt = lay_flags;
          hlen_nxt  = lay_hlen;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: result register
  // ---------------------------------------------------------------------------
  logic                out_vld_r;
  logic [STATUS_W-1:0] status_r;
  logic                cwv_r;
  logic                hvalid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [HLEN_W-1:0]   hlen_r;
  logic [TYPE_W-1:0]   type_r;
  logic [SUB_W-1:0]    sub_r;
  logic [FCBITS_W-1:0] fcbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_vld_r) begin
      status_r <= status_nxt;
      cwv_r    <= cwv_nxt;
      hvalid_r <= hvalid_nxt;
      kind_r   <= kind_nxt;
      flags_r  <= flags_nxt;
      hlen_r   <= hlen_nxt;
      type_r   <= type_nxt;
      sub_r    <= sub_nxt;
      fcbits_r <= fcbits_nxt;
    end
  end

  assign out_bus.valid               = out_vld_r;
  assign out_bus.status              = status_r;
  assign out_bus.control_word_valid  = cwv_r;
  assign out_bus.header_length_valid = hvalid_r;
  assign out_bus.hdr_layout          = kind_r;
  assign out_bus.field_flags         = flags_r;
  assign out_bus.min_header_bytes    = hlen_r;
  assign out_bus.fctl_type           = type_r;
  assign out_bus.frame_subtype       = sub_r;
  assign out_bus.frame_flag_bits     = fcbits_r;

endmodule : wlan_mac_header_layout_classifier

// File: tb/wlan_mac_header_layout_classifier_tb.sv
// Self-checking testbench for the WLAN MAC header layout classifier.
// Drives frame control / BAR-BA control / length beats and checks each result beat
// against a local predictor. Depends on whlc_pkg, whlc_ifs.sv and the block's RTL.
module wlan_mac_header_layout_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whlc_pkg::*;

  // Cycles with no accepted beat on either side before the run is abandoned.
  // The slowest correct run idles for at most a sender gap plus a sink stall plus
  // the pass through the input and result registers, so this is many times over.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 8;

  // Frame control flag masks
  localparam logic [WORD_W-1:0] FC_TODS_M   = 16'h0100;
  localparam logic [WORD_W-1:0] FC_FROMDS_M = 16'h0200;
  localparam logic [WORD_W-1:0] FC_ORDER_M  = 16'h8000;
  localparam int unsigned       FC_TODS     = 8;
  localparam int unsigned       FC_FROMDS   = 9;
  localparam int unsigned       FC_ORDER    = 15;

  // BAR/BA control masks
  localparam logic [WORD_W-1:0] ACK_MTID_M = 16'h1 << ACK_MULTI_TID_BIT;
  localparam logic [WORD_W-1:0] ACK_CBA_M  = 16'h1 << ACK_COMPRESSED_BIT;

  localparam logic [HLEN_W-1:0] HLEN_DATA_BASE = HLEN_MGMT;

  typedef struct packed {
    status_t             status;
    logic                cw_valid;
    logic                hl_valid;
    logic [KIND_W-1:0]   kind;
    logic [FLAGS_W-1:0]  flags;
    logic [HLEN_W-1:0]   hlen;
    logic [TYPE_W-1:0]   ftype;
    logic [SUB_W-1:0]    fsub;
    logic [FCBITS_W-1:0] fbits;
  } hdr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  whlc_in_if  in_bus ();
  whlc_out_if out_bus ();

  wlan_mac_header_layout_classifier u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  hdr_result_t pending_headers[$];
  int unsigned mismatches   = 0;
  int unsigned headers_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  bit          src_gaps_on  = 1'b0;
  bit          snk_stalls_on = 1'b0;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: the layout a header should classify to.
  // ---------------------------------------------------------------------------
  function automatic hdr_result_t classify_header(logic [WORD_W-1:0] fc,
                                                  logic [WORD_W-1:0] ack,
                                                  logic [WORD_W-1:0] len);
    hdr_result_t        r;
    status_t            st;
    logic [KIND_W-1:0]  kind;
    logic [FLAGS_W-1:0] flags;
    logic [HLEN_W-1:0]  hlen;
    logic [SUB_W-1:0]   sub;
    r     = '0;
    st    = ST_OK;
    kind  = '0;
    flags = '0;
    hlen  = '0;
    sub   = fc[7:4];
    // Control word not even captured: truncated, all else zero
    if (len < LEN_FC_MIN) begin
      r.status = ST_TRUNC;
      return r;
    end
    r.cw_valid = 1'b1;
    r.ftype    = fc[3:2];
    r.fsub     = sub;
    r.fbits    = {fc[15:14], fc[11:8]};

    if (fc[1:0] != 2'b00) begin
      st = ST_VERSION;
    end else begin
      case (ftype_t'(fc[3:2]))
        FT_MGMT: begin
          if (sub inside {MSUB_RES_6, MSUB_RES_7, MSUB_RES_15}) begin
            st = ST_RESERVED;
          end else begin
            kind  = KIND_MGMT;
            flags = FL_A1 | FL_A2 | FL_A3;
            hlen  = HLEN_MGMT;
            if (fc[FC_ORDER]) begin
              flags |= FL_HT;
              hlen  += HLEN_HT;
            end
          end
        end
        FT_CTRL: begin
          case (sub)
            CSUB_WRAPPER: begin
              kind  = KIND_WRAPPER;
              flags = FL_A1 | FL_HT;
              hlen  = HLEN_WRAPPER;
            end
            CSUB_BAR, CSUB_BA: begin
              // BAR/BA control not captured: no layout at all
              if (len < LEN_ACK_MIN) begin
                st = ST_TRUNC;
              end else if (ack[ACK_MULTI_TID_BIT]) begin
                st = ST_EXT;
              end else if (sub == CSUB_BAR) begin
                kind  = KIND_BAR;
                flags = FL_A1 | FL_A2 | FL_BARC;
                hlen  = HLEN_BAR;
              end else if (!ack[ACK_COMPRESSED_BIT]) begin
                st = ST_EXT;
              end else begin
                kind  = KIND_CBA;
                flags = FL_A1 | FL_A2 | FL_BARC | FL_BITMAP;
                hlen  = HLEN_CBA;
              end
            end
            CSUB_PS_POLL, CSUB_RTS, CSUB_CF_END, CSUB_CF_END_ACK: begin
              kind  = KIND_CTRL2A;
              flags = FL_A1 | FL_A2;
              hlen  = HLEN_CTRL2A;
            end
            CSUB_CTS, CSUB_ACK: begin
              kind  = KIND_CTRL1A;
              flags = FL_A1;
              hlen  = HLEN_CTRL1A;
            end
            CSUB_TRIGGER, CSUB_CTRL_EXT: st = ST_SUBTYPE;
            default: st = ST_RESERVED;
          endcase
        end
        FT_DATA: begin
          kind  = KIND_DATA;
          flags = FL_A1 | FL_A2 | FL_A3;
          hlen  = HLEN_DATA_BASE;
          if (fc[FC_TODS] && fc[FC_FROMDS]) begin
            flags |= FL_A4;
            hlen  += HLEN_A4;
          end
          if (sub[DSUB_QOS_BIT]) begin
            flags |= FL_QOS;
            hlen  += HLEN_QOS;
            if (fc[FC_ORDER]) begin
              flags |= FL_HT;
              hlen  += HLEN_HT;
            end
          end
        end
        default: st = ST_TYPE;
      endcase
    end

    // Layout found; it may still be longer than what was captured
    r.hl_valid = (st == ST_OK);
    if (st == ST_OK && len < hlen) st = ST_TRUNC;
    r.status = st;
    if (st == ST_OK) begin
      r.kind  = kind;
      r.flags = flags;
      r.hlen  = hlen;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mk_fc(ftype_t t, logic [SUB_W-1:0] sub,
                                              logic [WORD_W-1:0] extra);
    logic [WORD_W-1:0] fc;
    fc      = extra;
    fc[3:2] = t;
    fc[7:4] = sub;
    return fc;
  endfunction

  // Lengths cluster round the header thresholds, with the odd full-range one
  function automatic logic [WORD_W-1:0] pick_length();
    case ($urandom_range(0, 4))
      0:       return WORD_W'($urandom_range(0, 3));
      1:       return WORD_W'($urandom_range(4, 40));
      2:       return WORD_W'($urandom_range(8, 37));
      3:       return WORD_W'($urandom_range(0, 255));
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Version bits cleared, everything else above the subtype random
  function automatic logic [WORD_W-1:0] rand_fc_flags();
    return WORD_W'($urandom) & 16'hff00;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: records accepted beats, checks results, runs the watchdog.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    hdr_result_t want;
    hdr_result_t got;
    bit          moved;
    if (rst_n) begin
      moved = 1'b0;
      // Input side first so the order within the step never matters
      if (in_bus.valid && in_bus.ready) begin
        pending_headers.push_back(classify_header(in_bus.fctl_word,
                                                  in_bus.ack_control,
                                                  in_bus.frame_length));
        moved = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        got.status   = status_t'(out_bus.status);
        got.cw_valid = out_bus.control_word_valid;
        got.hl_valid = out_bus.header_length_valid;
        got.kind     = out_bus.hdr_layout;
        got.flags    = out_bus.field_flags;
        got.hlen     = out_bus.min_header_bytes;
        got.ftype    = out_bus.fctl_type;
        got.fsub     = out_bus.frame_subtype;
        got.fbits    = out_bus.frame_flag_bits;
        if (pending_headers.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with none expected: expected nothing, actual 0x%0h",
                   $time, got);
        end else begin
          want = pending_headers.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("control_word_valid", 16'(want.cw_valid), 16'(got.cw_valid));
          check_field("header_length_valid", 16'(want.hl_valid), 16'(got.hl_valid));
          check_field("hdr_layout", 16'(want.kind), 16'(got.kind));
          check_field("field_flags", 16'(want.flags), 16'(got.flags));
          check_field("min_header_bytes", 16'(want.hlen), 16'(got.hlen));
          check_field("fctl_type", 16'(want.ftype), 16'(got.ftype));
          check_field("frame_subtype", 16'(want.fsub), 16'(got.fsub));
          check_field("frame_flag_bits", 16'(want.fbits), 16'(got.fbits));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat accepted for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_headers.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result sink: ready drops in random stall bursts when enabled
  initial begin
    int unsigned stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (snk_stalls_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at a falling edge with valid
  // left high unless a gap was inserted.
  // ---------------------------------------------------------------------------
  task automatic send_header(logic [WORD_W-1:0] fc, logic [WORD_W-1:0] ack,
                             logic [WORD_W-1:0] len);
    int unsigned gap;
    in_bus.valid        <= 1'b1;
    in_bus.fctl_word    <= fc;
    in_bus.ack_control  <= ack;
    in_bus.frame_length <= len;
    do @(posedge clk); while (!in_bus.ready);
    headers_sent++;
    @(negedge clk);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_headers.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // capture too short for the control word
    send_header(16'hffff, 16'hffff, 16'd0);
    send_header(16'hffff, 16'h0000, 16'd1);
    // layout found but only two bytes captured
    send_header(mk_fc(FT_MGMT, MSUB_ASSOC_REQ, '0), '0, 16'd2);
    // nonzero versions, still decoded, and an extension-type frame
    send_header(16'hffff, 16'hffff, 16'hffff);
    send_header(mk_fc(FT_DATA, DSUB_DATA, 16'h0001), '0, 16'd100);
    send_header(mk_fc(FT_EXT, MSUB_ASSOC_REQ, '0), '0, 16'd100);
    // management: plain, with HT control, reserved subtypes
    send_header(mk_fc(FT_MGMT, MSUB_ASSOC_REQ, '0), '0, 16'd24);
    send_header(mk_fc(FT_MGMT, MSUB_ASSOC_REQ, FC_ORDER_M), '0, 16'd27);
    send_header(mk_fc(FT_MGMT, MSUB_ASSOC_REQ, FC_ORDER_M), '0, 16'd28);
    send_header(mk_fc(FT_MGMT, MSUB_RES_6, '0), '0, 16'd64);
    send_header(mk_fc(FT_MGMT, MSUB_RES_15, '0), '0, 16'd64);
    // control wrapper, BAR at and around its limits
    send_header(mk_fc(FT_CTRL, CSUB_WRAPPER, '0), '0, 16'd16);
    send_header(mk_fc(FT_CTRL, CSUB_BAR, '0), 16'hffff, 16'd17);
    send_header(mk_fc(FT_CTRL, CSUB_BAR, '0), '0, 16'd18);
    send_header(mk_fc(FT_CTRL, CSUB_BAR, '0), '0, 16'd20);
    send_header(mk_fc(FT_CTRL, CSUB_BAR, '0), ACK_MTID_M, 16'd20);
    // BA: compressed, basic, multi-TID
    send_header(mk_fc(FT_CTRL, CSUB_BA, '0), ACK_CBA_M, 16'd28);
    send_header(mk_fc(FT_CTRL, CSUB_BA, '0), '0, 16'd64);
    send_header(mk_fc(FT_CTRL, CSUB_BA, '0), ACK_CBA_M | ACK_MTID_M, 16'd64);
    // short control frames; trigger, control extension, reserved
    send_header(mk_fc(FT_CTRL, CSUB_RTS, '0), '0, 16'd16);
    send_header(mk_fc(FT_CTRL, CSUB_CTS, '0), '0, 16'd9);
    send_header(mk_fc(FT_CTRL, CSUB_ACK, '0), '0, 16'd10);
    send_header(mk_fc(FT_CTRL, CSUB_TRIGGER, '0), '0, 16'd64);
    send_header(mk_fc(FT_CTRL, CSUB_CTRL_EXT, '0), '0, 16'd64);
    send_header(mk_fc(FT_CTRL, CSUB_RESERVED0, '0), '0, 16'd64);
    // data: four-address, full QoS+HT header at and below its length
    send_header(mk_fc(FT_DATA, DSUB_DATA, FC_TODS_M | FC_FROMDS_M), '0, 16'd30);
    send_header(mk_fc(FT_DATA, DSUB_QOS_DATA, FC_TODS_M | FC_FROMDS_M | FC_ORDER_M),
                '0, 16'd36);
    send_header(mk_fc(FT_DATA, DSUB_QOS_DATA, FC_TODS_M | FC_FROMDS_M | FC_ORDER_M),
                '0, 16'd35);
  endtask

  task automatic test_management(int unsigned n);
    repeat (n) begin
      send_header(mk_fc(FT_MGMT, SUB_W'($urandom), rand_fc_flags()),
                  WORD_W'($urandom), pick_length());
    end
  endtask

  task automatic test_control(int unsigned n);
    logic [SUB_W-1:0]  sub;
    logic [WORD_W-1:0] ack;
    repeat (n) begin
      // half the traffic on BAR/BA, mostly with well-formed control words
      sub = $urandom_range(0, 1) ? SUB_W'($urandom_range(CSUB_BAR, CSUB_BA))
                                 : SUB_W'($urandom);
      ack = WORD_W'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        ack[ACK_MULTI_TID_BIT]  = 1'b0;
        ack[ACK_COMPRESSED_BIT] = ($urandom_range(0, 3) != 0);
      end
      send_header(mk_fc(FT_CTRL, sub, rand_fc_flags()), ack, pick_length());
    end
  endtask

  task automatic test_data(int unsigned n);
    repeat (n) begin
      send_header(mk_fc(FT_DATA, SUB_W'($urandom), rand_fc_flags()),
                  WORD_W'($urandom), pick_length());
    end
  endtask

  // Unconstrained words: bad versions, extension type, any length
  task automatic test_malformed(int unsigned n);
    repeat (n) begin
      send_header(WORD_W'($urandom), WORD_W'($urandom),
                  $urandom_range(0, 1) ? pick_length() : WORD_W'($urandom));
    end
  endtask

  // Any well-formed type, no gaps or stalls: back-to-back through the pipeline
  task automatic test_back_to_back(int unsigned n);
    repeat (n) begin
      send_header(mk_fc(ftype_t'($urandom_range(0, 2)), SUB_W'($urandom), rand_fc_flags()),
                  WORD_W'($urandom), pick_length());
    end
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.fctl_word    = '0;
    in_bus.ack_control  = '0;
    in_bus.frame_length = '0;
    rst_n               = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_gaps_on   = 1'b1;
    snk_stalls_on = 1'b1;
    test_directed();
    drain_results();
    test_management(300);
    drain_results();
    test_control(450);
    drain_results();
    snk_stalls_on = 1'b0;
    test_data(350);
    src_gaps_on   = 1'b0;
    snk_stalls_on = 1'b1;
    test_malformed(300);
    drain_results();
    src_gaps_on   = 1'b0;
    snk_stalls_on = 1'b0;
    test_back_to_back(300);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Classified %0d headers (directed edges, management, control incl. BAR/BA,",
             headers_sent);
    $display("data, malformed, back-to-back); %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && pending_headers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : wlan_mac_header_layout_classifier_tb
